@@ design/rns_pkg.sv @@
// Shared types and constants for the range negate / range sum tree.
package rns_pkg;

  localparam int DEF_MAX_ELEMENTS = 1024;
  localparam int DEF_TREE_NODES   = 4096;
  localparam int CMDQ_DEPTH       = 2;
  localparam int IDX_W            = 10;
  localparam int DATA_W           = 32;
  localparam int CNT_W            = 11;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_FLIP = 2'd1,
    ACT_SUM  = 2'd2
  } action_t;

  // Work kinds handed from front to back; K_ZERO is a sum that covers nothing.
  typedef enum logic [1:0] {
    K_LOAD = 2'd0,
    K_FLIP = 2'd1,
    K_SUM  = 2'd2,
    K_ZERO = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [IDX_W-1:0]   lo;
    logic [IDX_W-1:0]   hi;
    logic [DATA_W-1:0]  val;
  } cmd_t;

  typedef struct packed {
    logic               pend;
    logic [DATA_W-1:0]  sum;
  } node_t;

endpackage

@@ design/range_negate_range_sum_tree.sv @@
// Range negate / range sum tree: signed 32-bit elements kept as a segment tree
// of partial sums with a pending-negate bit per node, all in one node memory
// with one read and one write port. Items are handled one at a time by the
// tree walker, and the node memory's single read port sets the pace. A load
// walks down every tree level to its leaf and sums back up on the way out. A
// negate or sum stops at each covered node and splits each partly covered one,
// pushing any pending negate down to its children first. Sum results wait in
// an output register, and the front keeps queueing items meanwhile. After
// reset, and after each element_count write, a clearing pass wipes every node
// of node memory; full stays high during that pass.
module range_negate_range_sum_tree
  import rns_pkg::*;
#(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int TREE_NODES   = DEF_TREE_NODES
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [1:0]               action,
  input  logic [IDX_W-1:0]         range_low,
  input  logic [IDX_W-1:0]         range_high,
  input  logic signed [DATA_W-1:0] element_value,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [DATA_W-1:0] range_sum,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CNT_W-1:0]         element_count
);

  localparam int IW = $clog2(MAX_ELEMENTS) + 1;
  localparam int XW = (IW > CNT_W) ? IW : CNT_W;

  logic [XW-1:0]     count;
  logic [XW-1:0]     last;
  logic [XW-1:0]     cfg_x;
  logic              cfg_wr;
  logic              take;
  logic              enq;
  cmd_t              enq_cmd;
  cmd_t              deq_cmd;
  logic              q_full;
  logic              q_empty;
  logic              cmd_pop;
  logic              clearing;
  logic              res_valid;
  logic [DATA_W-1:0] res_sum;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_x     = XW'(element_count);
  assign last      = count - 1'b1;
  assign full      = q_full || clearing;
  assign take      = push && !full;
  assign empty     = !res_valid;
  assign range_sum = res_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= XW'(MAX_ELEMENTS);
    end else if (cfg_wr) begin
      // clamp the count into one .. MAX_ELEMENTS
      if (cfg_x == '0) begin
        count <= XW'(1);
      end else if (cfg_x > XW'(MAX_ELEMENTS)) begin
        count <= XW'(MAX_ELEMENTS);
      end else begin
        count <= cfg_x;
      end
    end
  end

  rns_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_front (
    .take          (take),
    .action        (action),
    .range_low     (range_low),
    .range_high    (range_high),
    .element_value (element_value),
    .last          (last),
    .enq           (enq),
    .cmd           (enq_cmd)
  );

  rns_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst     (rst || cfg_wr),
    .wr_en   (enq),
    .wr_data (enq_cmd),
    .q_full  (q_full),
    .rd_en   (cmd_pop),
    .rd_data (deq_cmd),
    .q_empty (q_empty)
  );

  rns_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .TREE_NODES   (TREE_NODES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .clear_start (cfg_wr),
    .last        (last),
    .cmd_valid   (!q_empty),
    .cmd         (deq_cmd),
    .cmd_pop     (cmd_pop),
    .clearing    (clearing),
    .res_valid   (res_valid),
    .res_sum     (res_sum),
    .res_pop     (pop && !empty)
  );

endmodule

@@ design/rns_ram.sv @@
// Generic single write port, single read port RAM with registered read.
module rns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/rns_cmdq.sv @@
// Short command queue between the front classifier and the tree walker.
module rns_cmdq
  import rns_pkg::*;
#(
  parameter int DEPTH = CMDQ_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic q_full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic q_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] fill;

  assign q_full  = (fill == CW'(DEPTH));
  assign q_empty = (fill == '0);
  assign rd_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (wr_en) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 1'b1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ design/rns_front.sv @@
// Front end: classifies accepted words into tree work or drops them.
module rns_front
  import rns_pkg::*;
#(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
  input  logic                      take,
  input  logic [1:0]                action,
  input  logic [IDX_W-1:0]          range_low,
  input  logic [IDX_W-1:0]          range_high,
  input  logic [DATA_W-1:0]         element_value,
  input  logic [((($clog2(MAX_ELEMENTS)+1) > CNT_W) ?
                 ($clog2(MAX_ELEMENTS)+1) : CNT_W)-1:0] last,
  output logic                      enq,
  output cmd_t                      cmd
);

  localparam int IW = $clog2(MAX_ELEMENTS) + 1;
  localparam int XW = (IW > CNT_W) ? IW : CNT_W;

  logic [XW-1:0] lo_x;
  logic [XW-1:0] hi_x;
  logic          span_ok;
  logic          keep;

  assign lo_x    = XW'(range_low);
  assign hi_x    = XW'(range_high);
  assign span_ok = (lo_x <= hi_x) && (hi_x <= last);
  assign enq     = take && keep;

  always_comb begin
    keep     = 1'b0;
    cmd.kind = K_SUM;
    cmd.lo   = range_low;
    cmd.hi   = range_high;
    cmd.val  = element_value;
    case (action_t'(action))
      ACT_LOAD: begin
        // a load walks as a one-element span
        keep     = (lo_x <= last);
        cmd.kind = K_LOAD;
        cmd.hi   = range_low;
      end
      ACT_FLIP: begin
        keep     = span_ok;
        cmd.kind = K_FLIP;
      end
      ACT_SUM: begin
        keep     = 1'b1;
        cmd.kind = span_ok ? K_SUM : K_ZERO;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

@@ design/rns_back.sv @@
// Back end: walks the segment tree in node memory with an explicit frame stack.
module rns_back
  import rns_pkg::*;
#(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int TREE_NODES   = DEF_TREE_NODES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clear_start,
  input  logic [((($clog2(MAX_ELEMENTS)+1) > CNT_W) ?
                 ($clog2(MAX_ELEMENTS)+1) : CNT_W)-1:0] last,
  input  logic                      cmd_valid,
  input  cmd_t                      cmd,
  output logic                      cmd_pop,
  output logic                      clearing,
  output logic                      res_valid,
  output logic [DATA_W-1:0]         res_sum,
  input  logic                      res_pop
);

  localparam int IW  = $clog2(MAX_ELEMENTS) + 1;
  localparam int XW  = (IW > CNT_W) ? IW : CNT_W;
  localparam int AW  = $clog2(TREE_NODES);
  localparam int NW  = AW + 1;
  localparam int SD  = $clog2(MAX_ELEMENTS) + 1;
  localparam int SW  = $clog2(SD);
  localparam int SPW = $clog2(SD + 1);
  localparam int NDW = DATA_W + 1;

  typedef struct packed {
    logic [NW-1:0] node;
    logic [XW-1:0] s;
    logic [XW-1:0] e;
    logic          ph;
  } frame_t;

  typedef enum logic [14:0] {
    ST_CLEAR  = 15'b000000000000001,
    ST_IDLE   = 15'b000000000000010,
    ST_ENTER  = 15'b000000000000100,
    ST_SUMRD  = 15'b000000000001000,
    ST_NEGRD  = 15'b000000000010000,
    ST_PDRD   = 15'b000000000100000,
    ST_PDLW   = 15'b000000001000000,
    ST_PDRW   = 15'b000000010000000,
    ST_PDCLR  = 15'b000000100000000,
    ST_CALLL  = 15'b000001000000000,
    ST_RESUME = 15'b000010000000000,
    ST_PU1    = 15'b000100000000000,
    ST_PU2    = 15'b001000000000000,
    ST_RET    = 15'b010000000000000,
    ST_DONE   = 15'b100000000000000
  } state_t;

  state_t            state;
  kind_t             kind;
  logic [XW-1:0]     lo;
  logic [XW-1:0]     hi;
  logic [DATA_W-1:0] val;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] nsum;
  logic [DATA_W-1:0] lsum;
  logic [NW-1:0]     node;
  logic [XW-1:0]     s_idx;
  logic [XW-1:0]     e_idx;
  logic              ph;
  frame_t            stack [SD];
  logic [SPW-1:0]    sp;
  logic [SPW-1:0]    sp_m1;
  logic [AW-1:0]     clr_addr;

  logic [NW-1:0]     left;
  logic [NW-1:0]     right;
  logic              node_ok;
  logic              right_ok;
  logic              left_ok;
  logic [XW:0]       se_sum;
  logic [XW-1:0]     mid;
  logic [XW-1:0]     mid1;
  logic              disjoint;
  logic              covered;
  logic              leaf;
  logic              lleaf;
  logic              rleaf;
  frame_t            cur_frame;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  node_t             ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [NDW-1:0]    ram_rdata;
  node_t             rd;

  rns_ram #(
    .WIDTH (NDW),
    .DEPTH (TREE_NODES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd        = node_t'(ram_rdata);
  assign left      = {node[NW-2:0], 1'b0};
  assign right     = {node[NW-2:0], 1'b1};
  assign node_ok   = node < NW'(TREE_NODES);
  assign left_ok   = left < NW'(TREE_NODES);
  assign right_ok  = right < NW'(TREE_NODES);
  assign se_sum    = {1'b0, s_idx} + {1'b0, e_idx};
  assign mid       = se_sum[XW:1];
  assign mid1      = mid + 1'b1;
  assign disjoint  = (e_idx < lo) || (s_idx > hi);
  assign covered   = (lo <= s_idx) && (e_idx <= hi);
  assign leaf      = (s_idx == e_idx);
  assign lleaf     = (s_idx == mid);
  assign rleaf     = (mid1 == e_idx);
  assign sp_m1     = sp - 1'b1;
  assign cur_frame = {node, s_idx, e_idx, 1'b0};
  assign clearing  = (state == ST_CLEAR);
  assign cmd_pop   = (state == ST_IDLE) && cmd_valid;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = node[AW-1:0];
    ram_wdata = '0;
    ram_raddr = node[AW-1:0];
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      ST_ENTER: begin
        // a covered node on a load walk is the leaf itself
        if (node_ok && !disjoint && covered && kind == K_LOAD) begin
          ram_we    = 1'b1;
          ram_wdata = '{pend: 1'b0, sum: val};
        end
      end
      ST_NEGRD: begin
        ram_we    = 1'b1;
        ram_wdata = '{pend: rd.pend ^ !leaf, sum: DATA_W'(0) - rd.sum};
      end
      ST_PDRD: begin
        ram_raddr = left[AW-1:0];
      end
      ST_PDLW: begin
        ram_we    = left_ok;
        ram_waddr = left[AW-1:0];
        ram_wdata = '{pend: rd.pend ^ !lleaf, sum: DATA_W'(0) - rd.sum};
        ram_raddr = right[AW-1:0];
      end
      ST_PDRW: begin
        ram_we    = right_ok;
        ram_waddr = right[AW-1:0];
        ram_wdata = '{pend: rd.pend ^ !rleaf, sum: DATA_W'(0) - rd.sum};
      end
      ST_PDCLR: begin
        ram_we    = 1'b1;
        ram_wdata = '{pend: 1'b0, sum: nsum};
      end
      ST_RESUME: begin
        ram_raddr = left[AW-1:0];
      end
      ST_PU1: begin
        ram_raddr = right[AW-1:0];
      end
      ST_PU2: begin
        ram_we    = 1'b1;
        ram_wdata = '{pend: 1'b0, sum: lsum + rd.sum};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      sp        <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_pop) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(TREE_NODES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            kind  <= cmd.kind;
            lo    <= XW'(cmd.lo);
            hi    <= XW'(cmd.hi);
            val   <= cmd.val;
            acc   <= '0;
            node  <= NW'(1);
            s_idx <= '0;
            e_idx <= last;
            sp    <= '0;
            state <= (cmd.kind == K_ZERO) ? ST_DONE : ST_ENTER;
          end
        end
        ST_ENTER: begin
          if (!node_ok || disjoint) begin
            state <= ST_RET;
          end else if (covered) begin
            case (kind)
              K_SUM:   state <= ST_SUMRD;
              K_FLIP:  state <= ST_NEGRD;
              default: state <= ST_RET;
            endcase
          end else begin
            state <= ST_PDRD;
          end
        end
        ST_SUMRD: begin
          acc   <= acc + rd.sum;
          state <= ST_RET;
        end
        ST_NEGRD: begin
          state <= ST_RET;
        end
        ST_PDRD: begin
          nsum  <= rd.sum;
          state <= rd.pend ? ST_PDLW : ST_CALLL;
        end
        ST_PDLW: begin
          state <= ST_PDRW;
        end
        ST_PDRW: begin
          state <= ST_PDCLR;
        end
        ST_PDCLR: begin
          state <= ST_CALLL;
        end
        ST_CALLL: begin
          stack[sp[SW-1:0]] <= cur_frame;
          sp    <= sp + 1'b1;
          node  <= left;
          e_idx <= mid;
          state <= ST_ENTER;
        end
        ST_RET: begin
          if (sp == '0) begin
            state <= ST_DONE;
          end else begin
            node  <= stack[sp_m1[SW-1:0]].node;
            s_idx <= stack[sp_m1[SW-1:0]].s;
            e_idx <= stack[sp_m1[SW-1:0]].e;
            ph    <= stack[sp_m1[SW-1:0]].ph;
            sp    <= sp_m1;
            state <= ST_RESUME;
          end
        end
        ST_RESUME: begin
          if (!ph) begin
            // left subtree done: save the frame again and go right
            stack[sp[SW-1:0]] <= {node, s_idx, e_idx, 1'b1};
            sp    <= sp + 1'b1;
            node  <= right;
            s_idx <= mid1;
            state <= ST_ENTER;
          end else if (kind != K_SUM && right_ok) begin
            state <= ST_PU1;
          end else begin
            state <= ST_RET;
          end
        end
        ST_PU1: begin
          lsum  <= rd.sum;
          state <= ST_PU2;
        end
        ST_PU2: begin
          state <= ST_RET;
        end
        ST_DONE: begin
          if (kind == K_SUM || kind == K_ZERO) begin
            if (!res_valid || res_pop) begin
              res_valid <= 1'b1;
              res_sum   <= acc;
              state     <= ST_IDLE;
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (clear_start) begin
        state    <= ST_CLEAR;
        clr_addr <= '0;
      end
    end
  end

endmodule

@@ design/rns_checker.sv @@
// Port-level checks for the range negate / range sum tree, bound to the top.
module rns_checker
  import rns_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     full,
  input logic                     empty,
  input logic                     pop,
  input logic signed [DATA_W-1:0] range_sum,
  input logic                     cfg_valid,
  input logic                     cfg_ready
);

  // memory is being cleared right after reset: no word may enter
  a_full_after_rst: assert property (@(posedge clk)
    $past(rst) && !rst |-> full)
    else $error("input not held off after reset");

  a_empty_after_rst: assert property (@(posedge clk)
    $past(rst) && !rst |-> empty)
    else $error("result shown right after reset");

  // a count write restarts the clearing pass
  a_full_after_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> full)
    else $error("input not held off after count write");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(range_sum))
    else $error("waiting result word changed or vanished");

endmodule

bind range_negate_range_sum_tree rns_checker u_rns_checker (.*);
